### design/escaped_serial_frame_parser_defines.svh
// assertion macros for the escaped serial frame parser
// included by the modules that check their own logic; no other dependencies
`ifndef ESCAPED_SERIAL_FRAME_PARSER_DEFINES_SVH
`define ESCAPED_SERIAL_FRAME_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

`define ESFP_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

`define ESFP_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`else

`define ESFP_ASSERT(label, clk, rst, prop, msg)

`define ESFP_ASSERT_ALWAYS(label, clk, prop, msg)

`endif

`endif

### design/esfp_pkg.sv
// shared types and constants for the escaped serial frame parser
// no dependencies
package esfp_pkg;

   localparam logic [7:0]  SYNC_BYTE  = 8'hFF;
   localparam logic [7:0]  STUFF_BYTE = 8'h55;
   localparam logic [15:0] MIN_LENGTH = 16'd5;

   typedef enum logic [1:0] {
      ST_BUSY = 2'd0,
      ST_OK   = 2'd1,
      ST_ERR  = 2'd2
   } status_type;

   typedef struct packed {
      status_type  status;
      logic        payload_valid;
      logic [7:0]  payload_byte;
      logic [7:0]  frame_command;
      logic [7:0]  frame_sequence;
      logic [15:0] frame_flags;
      logic [15:0] payload_length;
   } result_type;

endpackage

### design/esfp_if.sv
// handshake channels for the escaped serial frame parser: request and response
// depends on esfp_pkg
interface esfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

interface esfp_rsp_if import esfp_pkg::*; ();
   logic        valid;
   logic        ready;
   status_type  status;
   logic        payload_valid;
   logic [7:0]  payload_byte;
   logic [7:0]  frame_command;
   logic [7:0]  frame_sequence;
   logic [15:0] frame_flags;
   logic [15:0] payload_length;

   modport source (output valid, output status, output payload_valid, output payload_byte,
                   output frame_command, output frame_sequence, output frame_flags,
                   output payload_length, input ready);
   modport sink   (input valid, input status, input payload_valid, input payload_byte,
                   input frame_command, input frame_sequence, input frame_flags,
                   input payload_length, output ready);
endinterface

### design/esfp_parse.sv
// frame parser state and per-byte next-state logic
// depends on esfp_pkg and escaped_serial_frame_parser_defines.svh
`include "escaped_serial_frame_parser_defines.svh"

module esfp_parse import esfp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       step_valid,
   input  logic [7:0] rx_byte,
   output result_type result
);

   typedef enum logic [3:0] {
      PH_HUNT = 4'd0,
      PH_HDR1 = 4'd1,
      PH_HDR2 = 4'd2,
      PH_LEN1 = 4'd3,
      PH_LEN2 = 4'd4,
      PH_CMD  = 4'd5,
      PH_SEQ  = 4'd6,
      PH_FLG1 = 4'd7,
      PH_BODY = 4'd8
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [15:0] length_ff, length_in;
   logic [7:0]  sum_ff, sum_in;
   logic [7:0]  command_ff, command_in;
   logic [7:0]  sequence_ff, sequence_in;
   logic [15:0] flags_ff, flags_in;
   logic [15:0] count_ff, count_in;
   logic        escape_ff, escape_in;
   status_type  status;
   logic        pvalid;
   logic [7:0]  pbyte;
   logic [7:0]  sum_add;
   logic [15:0] body_length;

   assign sum_add     = sum_ff + rx_byte;
   assign body_length = length_ff - MIN_LENGTH;

   always_comb begin
      phase_in    = phase_ff;
      length_in   = length_ff;
      sum_in      = sum_ff;
      command_in  = command_ff;
      sequence_in = sequence_ff;
      flags_in    = flags_ff;
      count_in    = count_ff;
      escape_in   = escape_ff;
      status      = ST_BUSY;
      pvalid      = 1'b0;
      pbyte       = 8'h00;
      case (phase_ff)
         PH_HDR1: begin
            if (rx_byte == SYNC_BYTE) begin
               phase_in = PH_HDR2;
            end else begin
               status   = ST_ERR;
               phase_in = PH_HUNT;
            end
         end
         PH_HDR2: begin
            length_in = {rx_byte, 8'h00};
            sum_in    = sum_add;
            phase_in  = PH_LEN1;
         end
         PH_LEN1: begin
            length_in = {length_ff[15:8], rx_byte};
            sum_in    = sum_add;
            phase_in  = PH_LEN2;
         end
         PH_LEN2: begin
            command_in = rx_byte;
            sum_in     = sum_add;
            phase_in   = PH_CMD;
         end
         PH_CMD: begin
            sequence_in = rx_byte;
            sum_in      = sum_add;
            phase_in    = PH_SEQ;
         end
         PH_SEQ: begin
            flags_in = {rx_byte, 8'h00};
            sum_in   = sum_add;
            phase_in = PH_FLG1;
         end
         PH_FLG1: begin
            flags_in = {flags_ff[15:8], rx_byte};
            sum_in   = sum_add;
            phase_in = PH_BODY;
         end
         PH_BODY: begin
            if (length_ff < MIN_LENGTH) begin
               status   = ST_ERR;
               phase_in = PH_HUNT;
            end else if (escape_ff) begin
               if (rx_byte == STUFF_BYTE) begin
                  sum_in    = sum_add;
                  escape_in = 1'b0;
               end else begin
                  status   = ST_ERR;
                  phase_in = PH_HUNT;
               end
            end else if (count_ff == body_length) begin
               phase_in = PH_HUNT;
               status   = (rx_byte == sum_ff) ? ST_OK : ST_ERR;
            end else begin
               count_in  = count_ff + 16'd1;
               sum_in    = sum_add;
               pvalid    = 1'b1;
               pbyte     = rx_byte;
               escape_in = (rx_byte == SYNC_BYTE);
            end
         end
         default: begin
            // hunting, unused codes land here too
            if (rx_byte == SYNC_BYTE) begin
               phase_in    = PH_HDR1;
               length_in   = '0;
               sum_in      = '0;
               command_in  = '0;
               sequence_in = '0;
               flags_in    = '0;
               count_in    = '0;
               escape_in   = 1'b0;
            end else begin
               status   = ST_ERR;
               phase_in = PH_HUNT;
            end
         end
      endcase
   end

   always_comb begin
      result.status         = status;
      result.payload_valid  = pvalid;
      result.payload_byte   = pbyte;
      result.frame_command  = command_in;
      result.frame_sequence = sequence_in;
      result.frame_flags    = flags_in;
      result.payload_length = (length_in < MIN_LENGTH) ? 16'd0 : (length_in - MIN_LENGTH);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_HUNT;
         length_ff   <= '0;
         sum_ff      <= '0;
         command_ff  <= '0;
         sequence_ff <= '0;
         flags_ff    <= '0;
         count_ff    <= '0;
         escape_ff   <= 1'b0;
      end else if (step_valid) begin
         phase_ff    <= phase_in;
         length_ff   <= length_in;
         sum_ff      <= sum_in;
         command_ff  <= command_in;
         sequence_ff <= sequence_in;
         flags_ff    <= flags_in;
         count_ff    <= count_in;
         escape_ff   <= escape_in;
      end
   end

   `ESFP_ASSERT(a_ok_returns_to_hunt, clock, reset,
      step_valid && status == ST_OK |=> phase_ff == PH_HUNT,
      "frame ok did not return to hunting")

   `ESFP_ASSERT(a_err_returns_to_hunt, clock, reset,
      step_valid && status == ST_ERR |=> phase_ff == PH_HUNT && !$past(pvalid),
      "error did not return to hunting")

   `ESFP_ASSERT(a_sync_payload_arms_escape, clock, reset,
      step_valid && pvalid && rx_byte == SYNC_BYTE |=> escape_ff,
      "payload sync byte did not arm escape")

   `ESFP_ASSERT(a_count_within_length, clock, reset,
      phase_ff == PH_BODY && length_ff >= MIN_LENGTH |-> count_ff <= body_length,
      "payload count ran past frame length")

endmodule

### design/escaped_serial_frame_parser.sv
// escaped serial frame parser top level: input register, parser, result register
// depends on esfp_pkg, esfp_if, esfp_parse and escaped_serial_frame_parser_defines.svh
//
//   channel   direction  payload
//   req_bus   in         rx_byte
//   rsp_bus   out        status, payload_valid, payload_byte, frame_command,
//                        frame_sequence, frame_flags, payload_length
//
// one byte per cycle sustained while rsp_bus is ready; each beat is held in the input register
// and, once parsed, in the result register that drives rsp_bus
// the parse step is combinational logic between the input and result registers
// synchronous reset returns the parser to header hunting with all fields zero
// a stalled rsp_bus holds the result; req_bus keeps accepting until both registers fill
`include "escaped_serial_frame_parser_defines.svh"

module escaped_serial_frame_parser import esfp_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   esfp_req_if.sink   req_bus,
   esfp_rsp_if.source rsp_bus
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;
   logic       out_valid_ff, out_valid_in;
   result_type out_data_ff, out_data_in;
   result_type step_result;
   logic       advance;
   logic       req_fire;

   assign advance        = in_valid_ff && (!out_valid_ff || rsp_bus.ready);
   assign req_bus.ready  = !in_valid_ff || advance;
   assign req_fire       = req_bus.valid && req_bus.ready;

   esfp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .step_valid (advance),
      .rx_byte    (in_byte_ff),
      .result     (step_result)
   );

   always_comb begin
      in_valid_in  = in_valid_ff;
      in_byte_in   = in_byte_ff;
      out_valid_in = out_valid_ff;
      out_data_in  = out_data_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_bus.rx_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      if (advance) begin
         out_valid_in = 1'b1;
         out_data_in  = step_result;
      end else if (rsp_bus.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
      in_byte_ff  <= in_byte_in;
      out_data_ff <= out_data_in;
   end

   assign rsp_bus.valid          = out_valid_ff;
   assign rsp_bus.status         = out_data_ff.status;
   assign rsp_bus.payload_valid  = out_data_ff.payload_valid;
   assign rsp_bus.payload_byte   = out_data_ff.payload_byte;
   assign rsp_bus.frame_command  = out_data_ff.frame_command;
   assign rsp_bus.frame_sequence = out_data_ff.frame_sequence;
   assign rsp_bus.frame_flags    = out_data_ff.frame_flags;
   assign rsp_bus.payload_length = out_data_ff.payload_length;

   `ESFP_ASSERT(a_advance_fills_output, clock, reset,
      advance |=> out_valid_ff,
      "parsed beat did not reach the result register")

   `ESFP_ASSERT(a_full_pipe_blocks_input, clock, reset,
      in_valid_ff && out_valid_ff && !rsp_bus.ready |-> !req_bus.ready,
      "input accepted while both registers are full")

   `ESFP_ASSERT_ALWAYS(a_reset_clears_valids, clock,
      reset |=> !in_valid_ff && !out_valid_ff,
      "valid flags not cleared by reset")

endmodule

### tb/esfp_result_compare.sv
// parser predictor and response comparator for the escaped serial frame parser bench
// watches the request and response channels; depends on esfp_pkg and esfp_if
module esfp_result_compare import esfp_pkg::*; (
   input  logic clock,
   input  logic reset,
   esfp_req_if  req_mon,
   esfp_rsp_if  rsp_mon,
   output int   pending,
   output int   failures
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef enum logic [3:0] {
      SEEK_SYNC1 = 4'd0,
      SEEK_SYNC2 = 4'd1,
      LEN_HI     = 4'd2,
      LEN_LO     = 4'd3,
      CMD_FIELD  = 4'd4,
      SEQ_FIELD  = 4'd5,
      FLAGS_HI   = 4'd6,
      FLAGS_LO   = 4'd7,
      PAYLOAD    = 4'd8
   } frame_phase_type;

   frame_phase_type phase;
   logic [15:0]  frame_length;
   logic [7:0]   body_sum;
   logic [7:0]   frame_cmd;
   logic [7:0]   frame_seq;
   logic [15:0]  frame_flags;
   logic [15:0]  body_count;
   logic         stuff_due;
   result_type   expected_results[$];

   initial begin
      pending  = 0;
      failures = 0;
   end

   function automatic void clear_frame();
      frame_length = '0;
      body_sum     = '0;
      frame_cmd    = '0;
      frame_seq    = '0;
      frame_flags  = '0;
      body_count   = '0;
      stuff_due    = 1'b0;
   endfunction

   function automatic result_type parse_byte(input logic [7:0] b);
      result_type r;
      r = '0;
      r.status = ST_BUSY;
      case (phase)
         SEEK_SYNC2: begin
            if (b == SYNC_BYTE) phase = LEN_HI;
            else r.status = ST_ERR;
         end
         LEN_HI: begin
            frame_length = {b, 8'h00};
            body_sum = body_sum + b;
            phase = LEN_LO;
         end
         LEN_LO: begin
            frame_length[7:0] = b;
            body_sum = body_sum + b;
            phase = CMD_FIELD;
         end
         CMD_FIELD: begin
            frame_cmd = b;
            body_sum = body_sum + b;
            phase = SEQ_FIELD;
         end
         SEQ_FIELD: begin
            frame_seq = b;
            body_sum = body_sum + b;
            phase = FLAGS_HI;
         end
         FLAGS_HI: begin
            frame_flags = {b, 8'h00};
            body_sum = body_sum + b;
            phase = FLAGS_LO;
         end
         FLAGS_LO: begin
            frame_flags[7:0] = b;
            body_sum = body_sum + b;
            phase = PAYLOAD;
         end
         PAYLOAD: begin
            if (frame_length < MIN_LENGTH) begin
               r.status = ST_ERR;
            end else if (stuff_due) begin
               if (b == STUFF_BYTE) begin
                  body_sum = body_sum + b;
                  stuff_due = 1'b0;
               end else begin
                  r.status = ST_ERR;
               end
            end else if (body_count == frame_length - MIN_LENGTH) begin
               if (b == body_sum) begin
                  r.status = ST_OK;
                  phase = SEEK_SYNC1;
               end else begin
                  r.status = ST_ERR;
               end
            end else begin
               body_count = body_count + 16'd1;
               body_sum = body_sum + b;
               r.payload_valid = 1'b1;
               r.payload_byte = b;
               if (b == SYNC_BYTE) stuff_due = 1'b1;
            end
         end
         default: begin
            if (b == SYNC_BYTE) begin
               clear_frame();
               phase = SEEK_SYNC2;
            end else begin
               r.status = ST_ERR;
            end
         end
      endcase
      if (r.status == ST_ERR) begin
         phase = SEEK_SYNC1;
         r.payload_valid = 1'b0;
         r.payload_byte = '0;
      end
      r.frame_command  = frame_cmd;
      r.frame_sequence = frame_seq;
      r.frame_flags    = frame_flags;
      r.payload_length = (frame_length < MIN_LENGTH) ? 16'd0 : frame_length - MIN_LENGTH;
      return r;
   endfunction

   task automatic compare_result(input result_type want, input result_type seen);
      if (seen.status !== want.status) begin
         $error("status expected %0d actual %0d", want.status, seen.status);
         failures++;
      end
      if (seen.payload_valid !== want.payload_valid) begin
         $error("payload_valid expected %0d actual %0d", want.payload_valid, seen.payload_valid);
         failures++;
      end
      if (seen.payload_byte !== want.payload_byte) begin
         $error("payload_byte expected %0h actual %0h", want.payload_byte, seen.payload_byte);
         failures++;
      end
      if (seen.frame_command !== want.frame_command) begin
         $error("frame_command expected %0h actual %0h", want.frame_command, seen.frame_command);
         failures++;
      end
      if (seen.frame_sequence !== want.frame_sequence) begin
         $error("frame_sequence expected %0h actual %0h", want.frame_sequence,
                seen.frame_sequence);
         failures++;
      end
      if (seen.frame_flags !== want.frame_flags) begin
         $error("frame_flags expected %0h actual %0h", want.frame_flags, seen.frame_flags);
         failures++;
      end
      if (seen.payload_length !== want.payload_length) begin
         $error("payload_length expected %0d actual %0d", want.payload_length,
                seen.payload_length);
         failures++;
      end
   endtask

   always @(posedge clock) begin
      result_type seen;
      result_type want;
      if (reset) begin
         phase = SEEK_SYNC1;
         clear_frame();
         expected_results.delete();
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            seen.status         = rsp_mon.status;
            seen.payload_valid  = rsp_mon.payload_valid;
            seen.payload_byte   = rsp_mon.payload_byte;
            seen.frame_command  = rsp_mon.frame_command;
            seen.frame_sequence = rsp_mon.frame_sequence;
            seen.frame_flags    = rsp_mon.frame_flags;
            seen.payload_length = rsp_mon.payload_length;
            if (expected_results.size() == 0) begin
               $error("response beat with no byte outstanding");
               failures++;
            end else begin
               want = expected_results.pop_front();
               compare_result(want, seen);
            end
         end
         if (req_mon.valid && req_mon.ready)
            expected_results.push_back(parse_byte(req_mon.rx_byte));
      end
      pending = expected_results.size();
   end

endmodule

### tb/escaped_serial_frame_parser_tb.sv
// top of the escaped serial frame parser bench: clock, reset, frame stimulus and verdict
// depends on esfp_pkg, esfp_if, escaped_serial_frame_parser and esfp_result_compare
module escaped_serial_frame_parser_tb import esfp_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ITEM_TARGET = 550;
   localparam int CYCLE_LIMIT = 100000;

   localparam int FRAME_GOOD      = 0;
   localparam int FRAME_BAD_SUM   = 1;
   localparam int FRAME_BAD_STUFF = 2;
   localparam int FRAME_CUT       = 3;
   localparam int FRAME_SHORT     = 4;
   localparam int FRAME_NOISE     = 5;

   localparam logic [7:0] OPENING_BYTES [24] = '{
      8'h00,
      8'hFF, 8'h12,
      8'hFF, 8'hFF, 8'h00, 8'h04, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h7E,
      8'hFF, 8'hFF, 8'h00, 8'h07, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'h55, 8'h00, 8'h5B
   };

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic steady = 1'b0;
   int   sent_bytes = 0;
   int   cycle_count = 0;
   int   pending;
   int   failures;

   esfp_req_if req_bus ();
   esfp_rsp_if rsp_bus ();

   escaped_serial_frame_parser u_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   esfp_result_compare u_compare (
      .clock    (clock),
      .reset    (reset),
      .req_mon  (req_bus),
      .rsp_mon  (rsp_bus),
      .pending  (pending),
      .failures (failures)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready <= steady || ($urandom_range(99) >= 23);
   end

   task automatic send_byte(input logic [7:0] b);
      while (!steady && $urandom_range(99) < 23) begin
         req_bus.valid <= 1'b0;
         @(negedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.rx_byte <= b;
      do @(posedge clock); while (!req_bus.ready);
      @(negedge clock);
      sent_bytes++;
   endtask

   task automatic send_frame(input int kind);
      logic [7:0]  wire_q[$];
      logic [7:0]  sum;
      logic [7:0]  b;
      logic [15:0] len;
      logic [15:0] flags;
      int          count;
      int          stuff_at;
      count = ($urandom_range(19) == 0) ? $urandom_range(60, 30) : $urandom_range(10);
      if (kind == FRAME_BAD_STUFF && count == 0) count = 1;
      len = 16'(count) + MIN_LENGTH;
      if (kind == FRAME_SHORT) len = 16'($urandom_range(4));
      if (kind == FRAME_CUT) len = ($urandom_range(3) == 0) ? 16'hFFFF : 16'($urandom);
      flags = 16'($urandom);
      wire_q = {SYNC_BYTE, SYNC_BYTE, len[15:8], len[7:0], 8'($urandom), 8'($urandom),
                flags[15:8], flags[7:0]};
      stuff_at = (kind == FRAME_BAD_STUFF) ? $urandom_range(count - 1) : -1;
      case (kind)
         FRAME_NOISE: begin
            wire_q.delete();
            repeat ($urandom_range(6, 1))
               wire_q.push_back(($urandom_range(4) == 0) ? SYNC_BYTE : 8'($urandom));
         end
         FRAME_SHORT: wire_q.push_back(8'($urandom));
         FRAME_CUT: begin
            repeat ($urandom_range(6)) wire_q.push_back(8'($urandom));
            wire_q.push_back(SYNC_BYTE);
            wire_q.push_back(8'h00);
         end
         default: begin
            for (int i = 0; i < count; i++) begin
               b = ($urandom_range(99) < 15 || i == stuff_at) ? SYNC_BYTE : 8'($urandom);
               wire_q.push_back(b);
               if (b == SYNC_BYTE) begin
                  if (i == stuff_at) begin
                     do b = 8'($urandom); while (b == STUFF_BYTE);
                     wire_q.push_back(b);
                     break;
                  end
                  wire_q.push_back(STUFF_BYTE);
               end
            end
            if (kind != FRAME_BAD_STUFF) begin
               sum = '0;
               for (int i = 2; i < wire_q.size(); i++) sum = sum + wire_q[i];
               if (kind == FRAME_BAD_SUM) sum = sum ^ 8'($urandom_range(255, 1));
               wire_q.push_back(sum);
            end
         end
      endcase
      foreach (wire_q[i]) send_byte(wire_q[i]);
   endtask

   initial begin
      int frame_no;
      int pick;
      int kind;
      req_bus.valid   = 1'b0;
      req_bus.rx_byte = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (OPENING_BYTES[i]) send_byte(OPENING_BYTES[i]);

      frame_no = 0;
      while (sent_bytes < ITEM_TARGET) begin
         // quiet stretch with no gaps on either side
         steady <= (frame_no >= 12 && frame_no < 22);
         pick = $urandom_range(99);
         if (pick < 68)      kind = FRAME_GOOD;
         else if (pick < 76) kind = FRAME_BAD_SUM;
         else if (pick < 83) kind = FRAME_BAD_STUFF;
         else if (pick < 89) kind = FRAME_CUT;
         else if (pick < 94) kind = FRAME_SHORT;
         else                kind = FRAME_NOISE;
         send_frame(kind);
         frame_no++;
      end
      req_bus.valid <= 1'b0;

      while (pending != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      if (failures == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
